### src/pkerd_pkg.sv
package pkerd_pkg;

  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned PROBE_LIMIT = 64;

  localparam int unsigned SlotW  = $clog2(TABLE_SLOTS);
  localparam int unsigned ProbeW = $clog2(PROBE_LIMIT + 1);

  localparam logic [31:0] HashMul  = 32'd2654435761;
  localparam logic [15:0] CountMax = 16'hffff;

  localparam logic [31:0] WindowTicksRst     = 32'd2000;
  localparam logic [15:0] IoThresholdRst     = 16'd60;
  localparam logic [15:0] DeleteThresholdRst = 16'd30;

  // configuration register indexes
  localparam logic [1:0] CfgWindowTicks     = 2'd0;
  localparam logic [1:0] CfgIoThreshold     = 2'd1;
  localparam logic [1:0] CfgDeleteThreshold = 2'd2;

  typedef enum logic [1:0] {
    VRD_NONE     = 2'd0,
    VRD_CANARY   = 2'd1,
    VRD_IO_RATE  = 2'd2,
    VRD_MASS_DEL = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_WINDOW,
    ST_COUNT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] win_begin;
    logic [15:0] events;
    logic [15:0] deletes;
    logic        fired;
  } entry_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CountMax) ? v : v + 16'd1;
  endfunction

endpackage

### src/per_key_event_rate_detector.sv
// per-process event rate detector
//
// s_axis carries one file-access event per item: tdata holds the process id
// and the millisecond timestamp, tuser the canary, delete and exempt flags.
// m_axis returns one verdict item per event with the entry's window counts.
// cfg_* writes the window length and the two thresholds; cfg_ready_o is
// always high.
//
// entries live in one 1024-slot synchronous ram, read-modify-written once
// per non-exempt event. a lookup hashes the id and probes linearly, each
// probed slot taking an address step and a registered read data step; at
// most 64 slots are probed, after which the home slot is evicted. an
// exempt event skips the table and goes straight to its emit step. one
// event is in work at a time; the next is accepted the cycle after its
// result has moved into the output register.
// after reset every ram slot is swept clear, and no item is taken during
// the sweep; configuration writes are taken at any time. when m_axis
// stalls, the result stays in the output register and the next item
// finishes up to its emit step and waits there.
module per_key_event_rate_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // events in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // proc_id [31:0], time_now [63:32]
  input  logic [2:0]  s_axis_tuser,   // canary_hit [0], delete_op [1], exempt [2]
  // verdicts out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // event_count [15:0], delete_count [31:16]
  output logic [1:0]  m_axis_tuser    // verdict [1:0]
);

  localparam int unsigned SlotW  = pkerd_pkg::SlotW;
  localparam int unsigned ProbeW = pkerd_pkg::ProbeW;

  pkerd_pkg::state_e state_q, state_d;

  logic [31:0] window_q;
  logic [15:0] io_thr_q, del_thr_q;

  logic [SlotW-1:0]  addr_q, addr_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [ProbeW-1:0] probe_q, probe_d;
  logic              out_valid_q, out_valid_d;

  logic [31:0] key_q, key_d;
  logic [31:0] now_q, now_d;
  logic        canary_q, canary_d;
  logic        del_q, del_d;
  logic        count_en_q, count_en_d;
  pkerd_pkg::entry_t   ent_q, ent_d;
  pkerd_pkg::verdict_e verdict_q, verdict_d;
  logic [15:0]         res_ev_q, res_ev_d, res_del_q, res_del_d;
  pkerd_pkg::verdict_e out_verdict_q, out_verdict_d;
  logic [15:0]         out_ev_q, out_ev_d, out_del_q, out_del_d;

  pkerd_pkg::entry_t slot_mem [pkerd_pkg::TABLE_SLOTS];
  pkerd_pkg::entry_t rd_q;
  pkerd_pkg::entry_t mem_wdata;
  logic [SlotW-1:0]  mem_waddr;
  logic              mem_we;

  logic        in_acc, out_free, probe_hit, probe_last, sweep_last;
  logic [31:0] hash_prod;
  logic [32:0] window_end;
  logic        restart;
  logic [15:0] ev_inc, del_inc;
  logic        io_hit, del_hit;
  pkerd_pkg::entry_t fresh, counted;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign probe_hit   = !rd_q.valid || (rd_q.key == key_q);
  assign probe_last  = probe_q == ProbeW'(pkerd_pkg::PROBE_LIMIT - 1);
  assign sweep_last  = addr_q == SlotW'(pkerd_pkg::TABLE_SLOTS - 1);
  assign hash_prod   = key_q * pkerd_pkg::HashMul;

  // window restart test, sized so start + window cannot wrap
  assign window_end = {1'b0, ent_q.win_begin} + {1'b0, window_q};
  assign restart    = (ent_q.win_begin == '0) || ({1'b0, now_q} > window_end);

  assign ev_inc  = pkerd_pkg::sat_inc(ent_q.events);
  assign del_inc = del_q ? pkerd_pkg::sat_inc(ent_q.deletes) : ent_q.deletes;
  assign io_hit  = ev_inc >= io_thr_q;
  assign del_hit = del_inc >= del_thr_q;

  always_comb begin
    fresh       = '0;
    fresh.valid = 1'b1;
    fresh.key   = key_q;
    counted     = ent_q;
    if (count_en_q) begin
      counted.events  = ev_inc;
      counted.deletes = del_inc;
      counted.fired   = io_hit || del_hit;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pkerd_pkg::ST_CLEAR: begin
        if (sweep_last) state_d = pkerd_pkg::ST_IDLE;
      end
      pkerd_pkg::ST_IDLE: begin
        if (in_acc) state_d = s_axis_tuser[2] ? pkerd_pkg::ST_EMIT : pkerd_pkg::ST_HASH;
      end
      pkerd_pkg::ST_HASH:   state_d = pkerd_pkg::ST_READ;
      pkerd_pkg::ST_READ:   state_d = pkerd_pkg::ST_CHECK;
      pkerd_pkg::ST_CHECK: begin
        state_d = (probe_hit || probe_last) ? pkerd_pkg::ST_WINDOW : pkerd_pkg::ST_READ;
      end
      pkerd_pkg::ST_WINDOW: state_d = pkerd_pkg::ST_COUNT;
      pkerd_pkg::ST_COUNT:  state_d = pkerd_pkg::ST_EMIT;
      pkerd_pkg::ST_EMIT: begin
        if (out_free) state_d = pkerd_pkg::ST_IDLE;
      end
      default: state_d = pkerd_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot_q;
    mem_wdata     = counted;
    addr_d        = addr_q;
    slot_d        = slot_q;
    probe_d       = probe_q;
    key_d         = key_q;
    now_d         = now_q;
    canary_d      = canary_q;
    del_d         = del_q;
    count_en_d    = count_en_q;
    ent_d         = ent_q;
    verdict_d     = verdict_q;
    res_ev_d      = res_ev_q;
    res_del_d     = res_del_q;
    out_verdict_d = out_verdict_q;
    out_ev_d      = out_ev_q;
    out_del_d     = out_del_q;
    out_valid_d   = out_valid_q && !m_axis_tready;

    case (state_q)
      pkerd_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = '0;
        addr_d    = addr_q + SlotW'(1);
      end
      pkerd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        key_d     = s_axis_tdata[31:0];
        now_d     = s_axis_tdata[63:32];
        canary_d  = s_axis_tuser[0];
        del_d     = s_axis_tuser[1];
        probe_d   = '0;
        // exempt items bypass the table
        verdict_d = pkerd_pkg::VRD_NONE;
        res_ev_d  = '0;
        res_del_d = '0;
      end
      pkerd_pkg::ST_HASH: begin
        addr_d = hash_prod[SlotW-1:0];
        slot_d = hash_prod[SlotW-1:0];
      end
      pkerd_pkg::ST_READ: begin
      end
      pkerd_pkg::ST_CHECK: begin
        if (!rd_q.valid) begin
          ent_d  = fresh;
          slot_d = addr_q;
        end else if (rd_q.key == key_q) begin
          ent_d  = rd_q;
          slot_d = addr_q;
        end else if (probe_last) begin
          // probe exhausted: evict the home slot, still held in slot_q
          ent_d = fresh;
        end else begin
          addr_d  = addr_q + SlotW'(1);
          probe_d = probe_q + ProbeW'(1);
        end
      end
      pkerd_pkg::ST_WINDOW: begin
        verdict_d  = pkerd_pkg::VRD_NONE;
        count_en_d = !canary_q && !ent_q.fired;
        if (canary_q) begin
          if (!ent_q.fired) begin
            ent_d.fired = 1'b1;
            verdict_d   = pkerd_pkg::VRD_CANARY;
          end
        end else if (!ent_q.fired && restart) begin
          ent_d.win_begin = now_q;
          ent_d.events    = '0;
          ent_d.deletes   = '0;
        end
      end
      pkerd_pkg::ST_COUNT: begin
        mem_we    = 1'b1;
        res_ev_d  = counted.events;
        res_del_d = counted.deletes;
        if (count_en_q) begin
          if (io_hit)       verdict_d = pkerd_pkg::VRD_IO_RATE;
          else if (del_hit) verdict_d = pkerd_pkg::VRD_MASS_DEL;
        end
      end
      pkerd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          out_ev_d      = res_ev_q;
          out_del_d     = res_del_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pkerd_pkg::ST_CLEAR;
      addr_q      <= '0;
      probe_q     <= '0;
      out_valid_q <= 1'b0;
      window_q    <= pkerd_pkg::WindowTicksRst;
      io_thr_q    <= pkerd_pkg::IoThresholdRst;
      del_thr_q   <= pkerd_pkg::DeleteThresholdRst;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      probe_q     <= probe_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pkerd_pkg::CfgWindowTicks:     window_q  <= cfg_data_i;
          pkerd_pkg::CfgIoThreshold:     io_thr_q  <= cfg_data_i[15:0];
          pkerd_pkg::CfgDeleteThreshold: del_thr_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q        <= slot_d;
    key_q         <= key_d;
    now_q         <= now_d;
    canary_q      <= canary_d;
    del_q         <= del_d;
    count_en_q    <= count_en_d;
    ent_q         <= ent_d;
    verdict_q     <= verdict_d;
    res_ev_q      <= res_ev_d;
    res_del_q     <= res_del_d;
    out_verdict_q <= out_verdict_d;
    out_ev_q      <= out_ev_d;
    out_del_q     <= out_del_d;
  end

  // entry ram, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    rd_q <= slot_mem[addr_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_del_q, out_ev_q};
  assign m_axis_tuser  = out_verdict_q;

  // a result only appears after the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == pkerd_pkg::ST_EMIT))
    else $error("result item without emit step");

  // an accepted item leaves the idle state at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != pkerd_pkg::ST_IDLE)
    else $error("item accepted but no work started");

  // the probe never runs past its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pkerd_pkg::ST_CHECK |-> probe_q <= ProbeW'(pkerd_pkg::PROBE_LIMIT - 1))
    else $error("probe count beyond limit");

  // outside the clear sweep, the ram is written only in the step that follows the window step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != pkerd_pkg::ST_CLEAR) |-> $past(state_q == pkerd_pkg::ST_WINDOW))
    else $error("entry write outside read-modify-write");

endmodule
